>>> rtl/itdt_pkg.sv
// ---------------------------------------------------------------------------
// itdt_pkg: shared types and constants for integer to decimal text
// Character codes, digit width, sequencer states and the command bundle
// passed from the sequencer to the BCD shift unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package itdt_pkg;

  localparam int CHAR_W  = 6;
  localparam int DIGIT_W = 4;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 6'd45;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 6'd57;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_CONV = 3'b010,
    S_EMIT = 3'b100
  } state_t;

  typedef struct packed {
    logic load;
    logic dabble;
    logic shift_digit;
  } bcd_cmd_t;

endpackage

`default_nettype wire

>>> rtl/itdt_bcd_unit.sv
// ---------------------------------------------------------------------------
// itdt_bcd_unit: shift-and-add-3 binary to BCD converter
// Takes one magnitude bit per cycle into a BCD register, correcting each
// digit before the shift, then shifts out one digit per cycle, top first.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module itdt_bcd_unit
  import itdt_pkg::*;
#(
  parameter int VALUE_WIDTH = 32,
  parameter int NDIG        = 10
) (
  input  wire logic                   clk,
  input  wire bcd_cmd_t               cmd,
  input  wire logic [VALUE_WIDTH-1:0] load_mag,
  output logic      [DIGIT_W-1:0]     top_digit
);

  localparam int BCD_W = NDIG * DIGIT_W;

  logic [BCD_W-1:0]       bcd;
  logic [VALUE_WIDTH-1:0] mag;
  logic [BCD_W-1:0]       corrected;

  always_comb begin
    logic [DIGIT_W-1:0] dig;
    corrected = bcd;
    for (int i = 0; i < NDIG; i++) begin
      dig = bcd[i*DIGIT_W +: DIGIT_W];
      corrected[i*DIGIT_W +: DIGIT_W] = (dig >= 4'd5) ? dig + 4'd3 : dig;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bcd <= '0;
      mag <= load_mag;
    end else if (cmd.dabble) begin
      bcd <= {corrected[BCD_W-2:0], mag[VALUE_WIDTH-1]};
      mag <= {mag[VALUE_WIDTH-2:0], 1'b0};
    end else if (cmd.shift_digit) begin
      bcd <= {bcd[BCD_W-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
    end
  end

  assign top_digit = bcd[BCD_W-1 -: DIGIT_W];

endmodule

`default_nettype wire

>>> rtl/integer_to_decimal_text.sv
// ---------------------------------------------------------------------------
// integer_to_decimal_text: signed integer to ASCII decimal characters
// Converts one two's complement value into its decimal text, one character
// per strobe, minus sign first, digits most significant first.
// ---------------------------------------------------------------------------
// Usage:
//   Pulse start with value while busy is low; the item is taken at that edge
//   and busy rises on the next cycle.
//   Characters come out on character/last, each valid for exactly one cycle
//   while strobe is high. last marks the final character of an item.
//   A negative value gives '-' in the cycle after acceptance. Zero gives the
//   single character '0'. The most negative value converts correctly.
// Sequence:
//   busy stays high while the value is converted, one magnitude bit per
//   cycle, and then while its NDIG digits (10 at a width of 32) are shifted
//   out, one BCD digit per cycle with leading zeros dropped. The last character
//   is strobed in the first cycle with busy low; no new item is taken while busy.
// Reset:
//   rst returns the sequencer to idle and clears strobe; nothing is kept
//   between items. Results cannot be held off by the receiver.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module integer_to_decimal_text
  import itdt_pkg::*;
#(
  parameter int VALUE_WIDTH = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic signed [VALUE_WIDTH-1:0] value,
  output logic                               busy,
  output logic                               strobe,
  output logic             [CHAR_W-1:0]      character,
  output logic                               last
);

  localparam int NDIG   = ((VALUE_WIDTH * 1233) >> 12) + 1;
  localparam int BCNT_W = $clog2(VALUE_WIDTH);
  localparam int DCNT_W = $clog2(NDIG);

  state_t                 state;
  state_t                 state_next;
  bcd_cmd_t               cmd;
  logic                   started;
  logic [BCNT_W-1:0]      bcnt;
  logic [DCNT_W-1:0]      dcnt;
  logic [VALUE_WIDTH-1:0] value_u;
  logic                   negative;
  logic [VALUE_WIDTH-1:0] load_mag;
  logic [DIGIT_W-1:0]     top_digit;
  logic                   emit_now;

  assign value_u  = $unsigned(value);
  assign negative = value_u[VALUE_WIDTH-1];
  assign load_mag = negative ? (~value_u) + {{(VALUE_WIDTH-1){1'b0}}, 1'b1} : value_u;
  assign busy     = (state != S_IDLE);

  itdt_bcd_unit #(
    .VALUE_WIDTH(VALUE_WIDTH),
    .NDIG       (NDIG)
  ) u_bcd (
    .clk      (clk),
    .cmd      (cmd),
    .load_mag (load_mag),
    .top_digit(top_digit)
  );

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_CONV;
        end
      end
      S_CONV: begin
        cmd.dabble = 1'b1;
        if (bcnt == '0) state_next = S_EMIT;
      end
      S_EMIT: begin
        cmd.shift_digit = 1'b1;
        if (dcnt == '0) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign emit_now = (state == S_EMIT) && (started || (top_digit != '0) || (dcnt == '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      strobe  <= 1'b0;
      started <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= (cmd.load && negative) || emit_now;
      if (cmd.load) begin
        started <= 1'b0;
      end else if (emit_now) begin
        started <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bcnt      <= BCNT_W'(VALUE_WIDTH - 1);
      dcnt      <= DCNT_W'(NDIG - 1);
      character <= CHAR_MINUS;
      last      <= 1'b0;
    end else begin
      if (cmd.dabble) bcnt <= bcnt - BCNT_W'(1);
      if (cmd.shift_digit) dcnt <= dcnt - DCNT_W'(1);
      if (emit_now) begin
        character <= CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, top_digit};
        last      <= (dcnt == '0);
      end
    end
  end

  a_char_range: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (character == CHAR_MINUS) ||
               ((character >= CHAR_ZERO) && (character <= CHAR_NINE)))
    else $error("character out of range");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    strobe && (character == CHAR_MINUS) |-> !last)
    else $error("minus sign marked last");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_last_idle: assert property (@(posedge clk) disable iff (rst)
    strobe && last |-> !busy)
    else $error("last character while still busy");

endmodule

`default_nettype wire

>>> bench/testbench.sv
// ---------------------------------------------------------------------------
// testbench: integer to decimal text
// Feeds signed 32-bit values through the start/busy handshake and checks
// each strobed character against a local spelling of the value: minus sign
// first for negatives, digits most significant first, last marking the end.
// A directed set covers zero, the extremes and the digit count edges.
// Random values follow, mixing full-range words, small numbers and values
// around powers of ten. Random idle bursts are placed on the sending side.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import itdt_pkg::*;

  localparam int RANDOM_ITEMS = 165;
  localparam int CALM_TAIL    = 30;
  localparam int STALL_LIMIT  = 400;
  localparam int DRAIN_CYCLES = 60;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              fin;
  } text_char_t;

  class decimal_text_scoreboard;
    text_char_t expected_chars[$];
    int         errors;

    function new();
      errors = 0;
    endfunction

    function void note_value(logic [31:0] v);
      logic [31:0] mag;
      logic [3:0]  digits [0:9];
      int          count;
      count = 0;
      mag = v[31] ? -v : v;
      do begin
        digits[count] = 4'(mag % 10);
        count++;
        mag = mag / 10;
      end while (mag != 0);
      if (v[31]) expected_chars.push_back('{code: CHAR_MINUS, fin: 1'b0});
      for (int i = count - 1; i >= 0; i--) begin
        expected_chars.push_back('{code: CHAR_W'(CHAR_ZERO + digits[i]), fin: (i == 0)});
      end
    endfunction

    function void check_char(logic [CHAR_W-1:0] code, logic fin);
      text_char_t want;
      if (expected_chars.size() == 0) begin
        $display("%0t: unexpected character %0d last %0b", $time, code, fin);
        errors++;
        return;
      end
      want = expected_chars.pop_front();
      if (code !== want.code) begin
        $display("%0t: character expected %0d actual %0d", $time, want.code, code);
        errors++;
      end
      if (fin !== want.fin) begin
        $display("%0t: last expected %0b actual %0b", $time, want.fin, fin);
        errors++;
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic signed [31:0]       value = '0;
  logic                     busy;
  logic                     strobe;
  logic        [CHAR_W-1:0] character;
  logic                     last;

  decimal_text_scoreboard sb = new();
  int stalled_cycles = 0;

  integer_to_decimal_text #(.VALUE_WIDTH(32)) dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .value     (value),
    .busy      (busy),
    .strobe    (strobe),
    .character (character),
    .last      (last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note_value(value);
      if (strobe) sb.check_char(character, last);
      if ((start && !busy) || strobe) stalled_cycles = 0;
      else stalled_cycles++;
      if (stalled_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic logic [31:0] power_of_ten(int k);
    logic [31:0] p;
    p = 1;
    repeat (k) p = p * 10;
    return p;
  endfunction

  function automatic logic [31:0] random_value();
    logic [31:0] m;
    case ($urandom_range(0, 3))
      0: m = $urandom;
      1: m = $urandom_range(0, 20);
      2: m = power_of_ten($urandom_range(0, 9)) + $urandom_range(0, 2) - 1;
      default: m = $urandom_range(0, power_of_ten($urandom_range(1, 9)));
    endcase
    if ($urandom_range(0, 1)) m = -m;
    return m;
  endfunction

  task automatic send_value(input logic [31:0] v, input bit allow_idle);
    if (allow_idle && $urandom_range(0, 2) == 0) begin
      start <= 1'b0;
      if ($urandom_range(0, 1)) begin
        do @(posedge clk); while (busy);
      end
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    start <= 1'b1;
    value <= v;
    do @(posedge clk); while (busy);
  endtask

  logic [31:0] directed_values [] = '{
    32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, 32'd10, 32'hFFFF_FFF6, 32'd99, 32'd100,
    32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'd1000000000, 32'd999999999,
    -32'd999999999, 32'd123456789, 32'h5555_5555, 32'hAAAA_AAAA, 32'd5, -32'd7,
    32'd4294967286
  };

  initial begin
    int total;
    int sent;
    total = directed_values.size() + RANDOM_ITEMS;
    sent = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_values[i]) begin
      send_value(directed_values[i], 1'b1);
      sent++;
    end
    repeat (RANDOM_ITEMS) begin
      send_value(random_value(), sent < total - CALM_TAIL);
      sent++;
    end
    start <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
